@@ rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// Stepper command decoder package
// Widths, character codes, command codes and the result type shared by the
// stepper command decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int STORED_CHARS = 6;
    localparam int CNT_W        = $clog2(STORED_CHARS + 1);
    localparam int IDX_W        = $clog2(STORED_CHARS);

    localparam int CHAR_W = 8;
    localparam int CMD_W  = 3;
    localparam int ARG_W  = 14;
    localparam int PINS_W = 3;

    typedef logic [CHAR_W-1:0]                   char_t;
    typedef logic [STORED_CHARS-1:0][CHAR_W-1:0] store_t;
    typedef logic [CNT_W-1:0]                    count_t;

    localparam char_t CH_M  = 8'h4D;
    localparam char_t CH_S  = 8'h53;
    localparam char_t CH_T  = 8'h54;
    localparam char_t CH_A  = 8'h41;
    localparam char_t CH_F  = 8'h46;
    localparam char_t CH_E  = 8'h45;
    localparam char_t CH_D  = 8'h44;
    localparam char_t CH_H  = 8'h48;
    localparam char_t CH_0  = 8'h30;
    localparam char_t CH_1  = 8'h31;
    localparam char_t CH_2  = 8'h32;
    localparam char_t CH_3  = 8'h33;
    localparam char_t CH_4  = 8'h34;
    localparam char_t CH_6  = 8'h36;
    localparam char_t CH_8  = 8'h38;
    localparam char_t CH_9  = 8'h39;

    localparam logic [CMD_W-1:0] CMD_ENABLE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DISABLE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MICROSTEP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIRECTION = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STEPS     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ANGLE     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TURNS     = 3'd6;

    localparam logic [PINS_W-1:0] PINS_FULL = 3'b000;
    localparam logic [PINS_W-1:0] PINS_HALF = 3'b001;
    localparam logic [PINS_W-1:0] PINS_4    = 3'b010;
    localparam logic [PINS_W-1:0] PINS_8    = 3'b011;
    localparam logic [PINS_W-1:0] PINS_16   = 3'b100;
    localparam logic [PINS_W-1:0] PINS_32   = 3'b111;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              valid_res;
        logic [ARG_W-1:0]  argument;
        logic [PINS_W-1:0] microstep_pins;
        logic              direction;
    } res_t;

endpackage

@@ rtl/scd_char_if.sv @@
// ----------------------------------------------------------------------------
// Command byte channel
// Valid/ready channel that carries one command byte and its final-byte flag.
// ----------------------------------------------------------------------------
interface scd_char_if;
    import scd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

@@ rtl/scd_res_if.sv @@
// ----------------------------------------------------------------------------
// Decoded command channel
// Valid/ready channel that carries one decoded stepper command.
// ----------------------------------------------------------------------------
interface scd_res_if;
    import scd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic              valid_res;
    logic [ARG_W-1:0]  argument;
    logic [PINS_W-1:0] microstep_pins;
    logic              direction;

    modport source (output valid, output command, output valid_res, output argument,
                    output microstep_pins, output direction, input ready);
    modport sink   (input valid, input command, input valid_res, input argument,
                    input microstep_pins, input direction, output ready);
endinterface

@@ rtl/stepper_command_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Stepper command decoder
// Collects ASCII command bytes and emits one decoded command per final byte.
//
//   Channel   Dir   Beat contents
//   char_ch   in    char_in, last (one command byte)
//   res_ch    out   command, valid_res, argument, microstep_pins, direction
//
// One byte is taken per cycle unless a held frame stalls the input. A final
// byte captures the command into a frame register, which is decoded into the
// result register once that is free. Reset clears the byte count and all
// valid flags. A stalled result holds the frame and then the input.
// ----------------------------------------------------------------------------
module stepper_command_decoder_core (
    input  logic     clk,
    input  logic     rst_n,
    scd_char_if.sink char_ch,
    scd_res_if.source res_ch
);
    import scd_pkg::*;

    store_t store_reg;
    store_t store_next;
    count_t count_reg;
    count_t count_next;
    store_t ins_store;
    count_t ins_count;

    store_t frame_reg;
    count_t frame_count_reg;
    logic   frame_valid_reg;
    logic   frame_valid_next;

    res_t   dec_res;
    res_t   res_reg;
    logic   res_valid_reg;
    logic   res_valid_next;

    logic   accept;
    logic   capture;
    logic   frame_move;

    assign frame_move    = frame_valid_reg && (!res_valid_reg || res_ch.ready);
    assign char_ch.ready = !frame_valid_reg || frame_move;
    assign accept        = char_ch.valid && char_ch.ready;
    assign capture       = accept && char_ch.last;

    always_comb
    begin
        ins_store = store_reg;
        ins_count = count_reg;
        if (count_reg < CNT_W'(STORED_CHARS))
        begin
            ins_store[count_reg[IDX_W-1:0]] = char_ch.char_in;
            ins_count                       = count_reg + count_t'(1);
        end
    end

    always_comb
    begin
        store_next = store_reg;
        count_next = count_reg;
        if (accept)
        begin
            store_next = ins_store;
            count_next = char_ch.last ? '0 : ins_count;
        end
    end

    assign frame_valid_next = capture || (frame_valid_reg && !frame_move);
    assign res_valid_next   = frame_move || (res_valid_reg && !res_ch.ready);

    scd_decode u_decode (
        .chars (frame_reg),
        .count (frame_count_reg),
        .res   (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            frame_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            frame_valid_reg <= frame_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        if (capture)
        begin
            frame_reg       <= ins_store;
            frame_count_reg <= ins_count;
        end
        if (frame_move)
        begin
            res_reg <= dec_res;
        end
    end

    assign res_ch.valid          = res_valid_reg;
    assign res_ch.command        = res_reg.command;
    assign res_ch.valid_res      = res_reg.valid_res;
    assign res_ch.argument       = res_reg.argument;
    assign res_ch.microstep_pins = res_reg.microstep_pins;
    assign res_ch.direction      = res_reg.direction;

endmodule

@@ rtl/scd_decode.sv @@
// ----------------------------------------------------------------------------
// Stepper command field decoder
// Decodes a captured command frame into command code, argument and pin fields.
// ----------------------------------------------------------------------------
module scd_decode (
    input  scd_pkg::store_t chars,
    input  scd_pkg::count_t count,
    output scd_pkg::res_t   res
);
    import scd_pkg::*;

    logic [STORED_CHARS-1:0] present;
    logic [STORED_CHARS-1:0] is_digit;
    logic [13:0]             arg4;
    logic [13:0]             arg3;
    logic                    ok;
    res_t                    raw;

    always_comb
    begin
        for (int i = 0; i < STORED_CHARS; i++)
        begin
            present[i]  = (count > CNT_W'(i));
            is_digit[i] = present[i] && (chars[i] >= CH_0) && (chars[i] <= CH_9);
        end
    end

    assign arg4 = 14'(chars[2][3:0]) * 14'd1000 + 14'(chars[3][3:0]) * 14'd100
                + 14'(chars[4][3:0]) * 14'd10 + 14'(chars[5][3:0]);
    assign arg3 = 14'(chars[3][3:0]) * 14'd100 + 14'(chars[4][3:0]) * 14'd10
                + 14'(chars[5][3:0]);

    always_comb
    begin
        raw = '0;
        ok  = 1'b0;
        if (present[0] && chars[0] == CH_M && present[1])
        begin
            unique case (chars[1])
                CH_E:
                begin
                    raw.command = CMD_ENABLE;
                    ok          = 1'b1;
                end
                CH_D:
                begin
                    raw.command = CMD_DISABLE;
                    ok          = 1'b1;
                end
                CH_M:
                begin
                    raw.command = CMD_MICROSTEP;
                    if (present[2] && chars[2] == CH_S && present[3])
                    begin
                        if (chars[3] == CH_F)
                        begin
                            raw.microstep_pins = PINS_FULL;
                            ok                 = 1'b1;
                        end
                        else if (chars[3] == CH_H)
                        begin
                            raw.microstep_pins = PINS_HALF;
                            ok                 = 1'b1;
                        end
                        else if (present[4])
                        begin
                            if (chars[3] == CH_0 && chars[4] == CH_4)
                            begin
                                raw.microstep_pins = PINS_4;
                                ok                 = 1'b1;
                            end
                            else if (chars[3] == CH_0 && chars[4] == CH_8)
                            begin
                                raw.microstep_pins = PINS_8;
                                ok                 = 1'b1;
                            end
                            else if (chars[3] == CH_1 && chars[4] == CH_6)
                            begin
                                raw.microstep_pins = PINS_16;
                                ok                 = 1'b1;
                            end
                            else if (chars[3] == CH_3 && chars[4] == CH_2)
                            begin
                                raw.microstep_pins = PINS_32;
                                ok                 = 1'b1;
                            end
                        end
                    end
                end
                CH_T:
                begin
                    raw.command = CMD_DIRECTION;
                    if (present[2] && chars[2] == CH_A)
                    begin
                        raw.direction = 1'b0;
                        ok            = 1'b1;
                    end
                    else if (present[2] && chars[2] == CH_H)
                    begin
                        raw.direction = 1'b1;
                        ok            = 1'b1;
                    end
                end
                CH_S:
                begin
                    raw.command  = CMD_STEPS;
                    raw.argument = arg4;
                    ok           = &is_digit[5:2];
                end
                CH_A:
                begin
                    raw.command  = CMD_ANGLE;
                    raw.argument = arg4;
                    ok           = &is_digit[5:2];
                end
                CH_F:
                begin
                    raw.command  = CMD_TURNS;
                    raw.argument = arg3;
                    ok           = &is_digit[5:3];
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
        raw.valid_res = ok;
    end

    // An invalid command reports all fields as zero.
    assign res = ok ? raw : '0;

endmodule

@@ dv/scd_command_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper command decoder checker
// Watches the byte and result channels, keeps its own copy of the stored
// command bytes, decodes each finished command into the result it must
// produce and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module scd_command_checker (
    input  logic clk,
    input  logic rst_n,
    scd_char_if  char_ch,
    scd_res_if   res_ch,
    output int   fail_count,
    output int   outstanding
);
    import scd_pkg::*;

    char_t cmd_bytes [STORED_CHARS];
    int    byte_cnt;
    res_t  expected_cmds [$];

    function automatic int char_at(input int pos);
        if (pos >= byte_cnt)
        begin
            return -1;
        end
        return int'(cmd_bytes[pos]);
    endfunction

    function automatic bit parse_digits(input int pos, input int n,
                                        output logic [ARG_W-1:0] value);
        int c;
        value = '0;
        for (int i = 0; i < n; i++)
        begin
            c = char_at(pos + i);
            if (c < int'(CH_0) || c > int'(CH_9))
            begin
                return 1'b0;
            end
            value = ARG_W'(int'(value) * 10 + c - int'(CH_0));
        end
        return 1'b1;
    endfunction

    function automatic res_t decode_command();
        res_t             r;
        bit               ok;
        int               c3;
        int               c4;
        logic [ARG_W-1:0] arg;
        r  = '0;
        ok = 1'b0;
        c3 = char_at(3);
        c4 = char_at(4);
        if (char_at(0) == int'(CH_M))
        begin
            case (char_at(1))
                int'(CH_E):
                begin
                    r.command = CMD_ENABLE;
                    ok = 1'b1;
                end
                int'(CH_D):
                begin
                    r.command = CMD_DISABLE;
                    ok = 1'b1;
                end
                int'(CH_M):
                begin
                    if (char_at(2) == int'(CH_S))
                    begin
                        r.command = CMD_MICROSTEP;
                        ok = 1'b1;
                        if (c3 == int'(CH_F))
                        begin
                            r.microstep_pins = PINS_FULL;
                        end
                        else if (c3 == int'(CH_H))
                        begin
                            r.microstep_pins = PINS_HALF;
                        end
                        else if (c3 == int'(CH_0) && c4 == int'(CH_4))
                        begin
                            r.microstep_pins = PINS_4;
                        end
                        else if (c3 == int'(CH_0) && c4 == int'(CH_8))
                        begin
                            r.microstep_pins = PINS_8;
                        end
                        else if (c3 == int'(CH_1) && c4 == int'(CH_6))
                        begin
                            r.microstep_pins = PINS_16;
                        end
                        else if (c3 == int'(CH_3) && c4 == int'(CH_2))
                        begin
                            r.microstep_pins = PINS_32;
                        end
                        else
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                int'(CH_T):
                begin
                    r.command = CMD_DIRECTION;
                    ok = 1'b1;
                    if (char_at(2) == int'(CH_A))
                    begin
                        r.direction = 1'b0;
                    end
                    else if (char_at(2) == int'(CH_H))
                    begin
                        r.direction = 1'b1;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                int'(CH_S):
                begin
                    r.command  = CMD_STEPS;
                    ok         = parse_digits(2, 4, arg);
                    r.argument = arg;
                end
                int'(CH_A):
                begin
                    r.command  = CMD_ANGLE;
                    ok         = parse_digits(2, 4, arg);
                    r.argument = arg;
                end
                int'(CH_F):
                begin
                    r.command  = CMD_TURNS;
                    ok         = parse_digits(3, 3, arg);
                    r.argument = arg;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
        if (!ok)
        begin
            r = '0;
        end
        else
        begin
            r.valid_res = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            byte_cnt = 0;
            foreach (cmd_bytes[i])
            begin
                cmd_bytes[i] = '0;
            end
            expected_cmds.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("result beat with no command pending: command %0d, argument %0d",
                           res_ch.command, res_ch.argument);
                    fail_count++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("command", 32'(want.command), 32'(res_ch.command));
                    check_field("valid_res", 32'(want.valid_res), 32'(res_ch.valid_res));
                    check_field("argument", 32'(want.argument), 32'(res_ch.argument));
                    check_field("microstep_pins", 32'(want.microstep_pins),
                                32'(res_ch.microstep_pins));
                    check_field("direction", 32'(want.direction), 32'(res_ch.direction));
                end
            end
            if (char_ch.valid && char_ch.ready)
            begin
                if (byte_cnt < STORED_CHARS)
                begin
                    cmd_bytes[byte_cnt] = char_ch.char_in;
                    byte_cnt++;
                end
                if (char_ch.last)
                begin
                    expected_cmds.push_back(decode_command());
                    byte_cnt = 0;
                    foreach (cmd_bytes[i])
                    begin
                        cmd_bytes[i] = '0;
                    end
                end
            end
            outstanding <= expected_cmds.size();
        end
    end

endmodule

@@ dv/tb_stepper_command_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper command decoder testbench
// Sends directed and random ASCII motor commands byte by byte with random
// gaps on both channels, lets the checker predict and compare each decoded
// result, and reports the verdict once all results have drained.
// ----------------------------------------------------------------------------
module tb_stepper_command_decoder_core;
    import scd_pkg::*;

    localparam int MAX_GAP      = 13;
    localparam int RANDOM_BYTES = 1500;
    localparam int DRAIN_CYCLES = 10;

    typedef char_t bytes_t [$];

    logic clk;
    logic rst_n;
    bit   quiet;
    int   fail_count;
    int   outstanding;
    int   bytes_sent;

    scd_char_if char_ch ();
    scd_res_if  res_ch ();

    stepper_command_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .char_ch(char_ch),
        .res_ch (res_ch)
    );

    scd_command_checker cmd_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_ch    (char_ch),
        .res_ch     (res_ch),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic bytes_t well_formed_cmd();
        bytes_t b;
        int     kind;
        b    = {CH_M};
        kind = $urandom_range(0, 6);
        case (kind)
            0:
            begin
                b.push_back(CH_E);
            end
            1:
            begin
                b.push_back(CH_D);
            end
            2:
            begin
                b = {b, CH_M, CH_S};
                case ($urandom_range(0, 5))
                    0:       b.push_back(CH_F);
                    1:       b.push_back(CH_H);
                    2:       b = {b, CH_0, CH_4};
                    3:       b = {b, CH_0, CH_8};
                    4:       b = {b, CH_1, CH_6};
                    default: b = {b, CH_3, CH_2};
                endcase
            end
            3:
            begin
                b = {b, CH_T, ($urandom_range(0, 1) ? CH_A : CH_H)};
            end
            4, 5:
            begin
                b.push_back(kind == 4 ? CH_S : CH_A);
                repeat (4)
                begin
                    b.push_back(CH_0 + char_t'($urandom_range(0, 9)));
                end
            end
            default:
            begin
                b = {b, CH_F, char_t'($urandom_range(0, 255))};
                repeat (3)
                begin
                    b.push_back(CH_0 + char_t'($urandom_range(0, 9)));
                end
            end
        endcase
        return b;
    endfunction

    task automatic send_byte(input char_t c, input logic fin);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= c;
        char_ch.last    <= fin;
        @(posedge clk);
        while (!char_ch.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_cmd(input bytes_t b);
        foreach (b[i])
        begin
            send_byte(b[i], i == b.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        bytes_t b;
        for (int i = 0; i < s.len(); i++)
        begin
            b.push_back(char_t'(s[i]));
        end
        send_cmd(b);
    endtask

    initial
    begin
        int hold;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                while (hold > 0)
                begin
                    @(posedge clk);
                    if (res_ch.valid)
                    begin
                        hold--;
                    end
                end
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        string  directed_cmds [] = '{"ME", "MD", "MMSF", "MMSH", "MMS04", "MMS08",
                                     "MMS16", "MMS32", "MMS05", "MMS3", "MMA",
                                     "MTA", "MTH", "MTX", "MS0000", "MS9999",
                                     "MA5678", "MF-123", "MF.99x", "MS12a4", "MS12",
                                     "M", "XE", "MEXYZ0123"};
        bytes_t cmd;
        int     start_bytes;
        int     cmd_no;
        int     n;

        quiet           = 1'b0;
        bytes_sent      = 0;
        cmd_no          = 0;
        rst_n           <= 1'b0;
        char_ch.valid   <= 1'b0;
        char_ch.char_in <= '0;
        char_ch.last    <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_cmds[i])
        begin
            send_text(directed_cmds[i]);
        end
        cmd = {8'h00};
        send_cmd(cmd);
        cmd = {CH_M, 8'hFF, 8'h00};
        send_cmd(cmd);

        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            cmd_no++;
            if (cmd_no % 40 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            cmd = well_formed_cmd();
            case ($urandom_range(0, 15))
                0:
                begin
                    cmd[$urandom_range(0, cmd.size() - 1)] = char_t'($urandom_range(0, 255));
                end
                1:
                begin
                    n = $urandom_range(1, cmd.size());
                    while (cmd.size() > n)
                    begin
                        void'(cmd.pop_back());
                    end
                end
                2:
                begin
                    cmd = {};
                    repeat ($urandom_range(1, 9))
                    begin
                        cmd.push_back(char_t'($urandom_range(0, 255)));
                    end
                end
                3, 4:
                begin
                    repeat ($urandom_range(1, 5))
                    begin
                        cmd.push_back(char_t'($urandom_range(0, 255)));
                    end
                end
                default:
                begin
                end
            endcase
            send_cmd(cmd);
        end

        char_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
